// ===== sv/hlxfr_pkg.sv =====
// package with frame constants, result codes and phase type for the frame receiver
`default_nettype none

package hlxfr_pkg;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;

  // header, separator characters
  localparam logic [ByteW-1:0] CH_U     = 8'h55;
  localparam logic [ByteW-1:0] CH_N     = 8'h4E;
  localparam logic [ByteW-1:0] CH_E     = 8'h45;
  localparam logic [ByteW-1:0] CH_R     = 8'h52;
  localparam logic [ByteW-1:0] CH_COLON = 8'h3A;

  // checksum seed: header and colon folded together
  localparam logic [ByteW-1:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

  // result kind codes
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_GOOD    = 2'd1;
  localparam logic [KindW-1:0] KIND_BAD     = 2'd2;

  // receive phase, one-hot
  typedef enum logic [6:0] {
    PH_HUNT    = 7'b000_0001,
    PH_WANT_N  = 7'b000_0010,
    PH_WANT_E  = 7'b000_0100,
    PH_WANT_R  = 7'b000_1000,
    PH_WANT_LEN = 7'b001_0000,
    PH_WANT_COL = 7'b010_0000,
    PH_PAYLOAD = 7'b100_0000
  } phase_e;

endpackage

`default_nettype wire

// ===== sv/hlxfr_byte_if.sv =====
// valid/ready channel carrying one received byte
`default_nettype none

interface hlxfr_byte_if;
  logic                          valid;
  logic                          ready;
  logic [hlxfr_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/hlxfr_result_if.sv =====
// valid/ready channel carrying one frame result
`default_nettype none

interface hlxfr_result_if;
  logic                          valid;
  logic                          ready;
  logic [hlxfr_pkg::KindW-1:0]   kind;
  logic [hlxfr_pkg::ByteW-1:0]   data;
  logic [hlxfr_pkg::ByteW-1:0]   position;

  modport source (output valid, output kind, output data, output position, input ready);
  modport sink   (input valid, input kind, input data, input position, output ready);
endinterface

`default_nettype wire

// ===== sv/header_length_xor_frame_receiver.sv =====
// top level: header, length and xor checksum frame receiver
//
//  channel  | dir | payload                 | notes
//  ---------+-----+-------------------------+-----------------------------------
//  rx_i     | in  | rx_byte[7:0]            | one serial byte per transfer
//  res_o    | out | kind, data, position    | payload byte or end-of-frame verdict
//
// one byte per cycle unless stalled; phase and result register update in the same cycle
// a result appears on res_o in the cycle after the byte that causes it
// rx_i.ready drops only while a result waits in the output register and res_o is stalled
// asynchronous active-low reset returns the receiver to hunting with empty output
`default_nettype none

module header_length_xor_frame_receiver (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  hlxfr_byte_if.sink           rx_i,
  hlxfr_result_if.source       res_o
);

  hlxfr_pkg::phase_e                phase_q, phase_d;
  logic [hlxfr_pkg::ByteW-1:0]      remaining_q, remaining_d;
  logic [hlxfr_pkg::ByteW-1:0]      xor_q, xor_d;
  logic [hlxfr_pkg::ByteW-1:0]      pos_q, pos_d;

  logic                             res_valid_q, res_valid_d;
  logic [hlxfr_pkg::KindW-1:0]      res_kind_q, res_kind_d;
  logic [hlxfr_pkg::ByteW-1:0]      res_data_q;
  logic [hlxfr_pkg::ByteW-1:0]      res_pos_q, res_pos_d;
  logic                             res_load;

  logic                             in_xfer;
  logic [hlxfr_pkg::ByteW-1:0]      b;
  logic [hlxfr_pkg::ByteW-1:0]      rem_dec;
  hlxfr_pkg::phase_e                hunt_phase;

  // accept whenever the output register is free or being drained
  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign in_xfer    = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign rem_dec    = remaining_q - 8'd1;

  // a mismatching byte is re-examined as a possible frame start
  assign hunt_phase = (b == hlxfr_pkg::CH_U) ? hlxfr_pkg::PH_WANT_N : hlxfr_pkg::PH_HUNT;

  // phase sequencing and result generation
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    xor_d       = xor_q;
    pos_d       = pos_q;
    res_load    = 1'b0;
    res_kind_d  = hlxfr_pkg::KIND_PAYLOAD;
    res_pos_d   = pos_q;
    if (in_xfer) begin
      case (phase_q)
        hlxfr_pkg::PH_HUNT: begin
          phase_d = hunt_phase;
        end
        hlxfr_pkg::PH_WANT_N: begin
          phase_d = (b == hlxfr_pkg::CH_N) ? hlxfr_pkg::PH_WANT_E : hunt_phase;
        end
        hlxfr_pkg::PH_WANT_E: begin
          phase_d = (b == hlxfr_pkg::CH_E) ? hlxfr_pkg::PH_WANT_R : hunt_phase;
        end
        hlxfr_pkg::PH_WANT_R: begin
          phase_d = (b == hlxfr_pkg::CH_R) ? hlxfr_pkg::PH_WANT_LEN : hunt_phase;
        end
        hlxfr_pkg::PH_WANT_LEN: begin
          remaining_d = b;
          phase_d     = hlxfr_pkg::PH_WANT_COL;
        end
        hlxfr_pkg::PH_WANT_COL: begin
          if (b == hlxfr_pkg::CH_COLON) begin
            phase_d = hlxfr_pkg::PH_PAYLOAD;
            pos_d   = '0;
            xor_d   = hlxfr_pkg::HDR_XOR ^ remaining_q;
          end else begin
            phase_d = hunt_phase;
          end
        end
        hlxfr_pkg::PH_PAYLOAD: begin
          remaining_d = rem_dec;
          res_load    = 1'b1;
          if (rem_dec != '0) begin
            res_kind_d = hlxfr_pkg::KIND_PAYLOAD;
            pos_d      = pos_q + 8'd1;
            xor_d      = xor_q ^ b;
          end else begin
            // last byte is the checksum
            res_kind_d = (xor_q == b) ? hlxfr_pkg::KIND_GOOD : hlxfr_pkg::KIND_BAD;
            phase_d    = hlxfr_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_d = hunt_phase;
        end
      endcase
    end
  end

  // output valid: set on a new result, cleared once transferred
  always_comb begin
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hlxfr_pkg::PH_HUNT;
      remaining_q <= '0;
      xor_q       <= '0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      xor_q       <= xor_d;
      pos_q       <= pos_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_kind_q <= res_kind_d;
      res_data_q <= b;
      res_pos_q  <= res_pos_d;
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.kind     = res_kind_q;
  assign res_o.data     = res_data_q;
  assign res_o.position = res_pos_q;

`ifndef SYNTHESIS
  // the checksum byte ends the frame with a verdict and returns to hunting
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (phase_q == hlxfr_pkg::PH_PAYLOAD) && (remaining_q == 8'd1)) |=>
    (res_valid_q && (res_kind_q != hlxfr_pkg::KIND_PAYLOAD) &&
     (phase_q == hlxfr_pkg::PH_HUNT)))
    else $error("checksum byte did not end the frame");

  // a length byte always leads to waiting for the colon
  a_len_to_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (phase_q == hlxfr_pkg::PH_WANT_LEN)) |=>
    (phase_q == hlxfr_pkg::PH_WANT_COL))
    else $error("length byte not followed by colon phase");

  // outside a frame body no result is produced
  a_no_result_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (phase_q != hlxfr_pkg::PH_PAYLOAD) && res_o.ready) |=> !res_valid_q)
    else $error("result produced outside payload phase");

  // only defined kind codes leave the block
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_kind_q == hlxfr_pkg::KIND_PAYLOAD ||
                     res_kind_q == hlxfr_pkg::KIND_GOOD ||
                     res_kind_q == hlxfr_pkg::KIND_BAD))
    else $error("undefined result kind");
`endif

endmodule

`default_nettype wire
